@@ design/wavetable_oscillator_exp_pitch_unit_macros.svh @@
// ----------------------------------------------------------------------------
// wavetable oscillator assertion macros
// shared concurrent assertion forms, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_EXP_PITCH_UNIT_MACROS_SVH
`define WAVETABLE_OSCILLATOR_EXP_PITCH_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WTOEP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WTOEP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wtoep_pkg.sv @@
// ----------------------------------------------------------------------------
// wtoep_pkg
// shared types and constants of the wavetable oscillator
// ----------------------------------------------------------------------------
package wtoep_pkg;

	localparam int unsigned WAVE_POINTS     = 257;
	localparam int unsigned EXP_ENTRIES     = 4096;
	localparam int unsigned WAVE_AW         = 9;
	localparam int unsigned EXP_AW          = 12;
	localparam int unsigned SAMPLE_W        = 16;
	localparam int unsigned TABLE_W         = 16;
	localparam int unsigned RATE_W          = 24;
	localparam int unsigned CV_W            = 15;
	localparam int unsigned PHASE_W         = 32;
	localparam logic [RATE_W-1:0] BASE_RATE_RESET = 24'h076D6A;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_SAMPLE  = 2'd0,
		REQ_WAVE_WR = 2'd1,
		REQ_EXP_WR  = 2'd2
	} req_t;

	// register enables from the sequencer to the datapath
	typedef struct packed {
		logic lo_load;
		logic fine_load;
		logic prod_load;
		logic inc_load;
		logic interp_load;
		logic scale_load;
		logic phase_step;
	} dp_ctl_t;

endpackage

@@ design/wavetable_oscillator_exp_pitch_unit.sv @@
// ----------------------------------------------------------------------------
// wavetable_oscillator_exp_pitch_unit
// wavetable oscillator with exponential pitch and amplitude modulation
// ----------------------------------------------------------------------------
// Each input transfer is a request selected by s_tuser. A sample request reads
// the 257-point wave table at the top 8 phase bits and at the next point,
// interpolates linearly with phase bits 23..8, scales by amp_mod halved and
// returns bits 47..32 of the product as one output transfer. The phase then
// advances by base_rate shifted left by the octave (pitch_cv 14..12), scaled
// by one plus the 16-bit fraction looked up in the exponent table at
// pitch_cv 11..0, and wraps at 32 bits. Wave and exponent write requests load
// the tables in the cycle of their transfer, give no output and leave the
// phase alone; a wave write with table_index above 256 and request kind 3 are
// dropped. Both tables come up unknown and must be loaded before sample
// requests use them. A sample request steps through RD_LO, RD_HI, MUL_DIFF,
// SUM, MUL_AMP and DONE from its input transfer until its result is in the
// output register; the one wave table read port gives the lo point, then
// its neighbor. The block takes its next request only when idle. A finished
// sample that finds the output register still full waits in its last step
// until the register drains. The output register lets a new request in while
// a result still waits. The user must write base_rate through the cfg channel
// only while the block is idle; the block itself does not enforce this.

`include "wavetable_oscillator_exp_pitch_unit_macros.svh"

module wavetable_oscillator_exp_pitch_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: base_rate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,      // base_rate[23:0]
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // amp_mod[15:0], pitch_cv[30:16],
	                                   // table_index[42:31], table_value[58:43], zero fill
	input  logic [1:0]  s_tuser,       // req_type[1:0]
	// sample stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata        // sample_out[15:0]
);
	import wtoep_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_MUL_DIFF,
		ST_SUM,
		ST_MUL_AMP,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [RATE_W-1:0]          base_rate_q;
	logic [CV_W-1:0]            pitch_cv_q;
	logic signed [SAMPLE_W-1:0] amp_mod_q;
	logic                       m_tvalid_q;
	logic [SAMPLE_W-1:0]        m_tdata_q;

	// unpacked request fields
	logic signed [SAMPLE_W-1:0] in_amp;
	logic [CV_W-1:0]            in_cv;
	logic [EXP_AW-1:0]          in_index;
	logic [TABLE_W-1:0]         in_value;

	logic in_xfer;
	logic out_free;

	dp_ctl_t ctl;

	// table ports
	logic                  wave_we;
	logic [WAVE_AW-1:0]    wave_waddr;
	logic                  wave_re;
	logic [WAVE_AW-1:0]    wave_raddr;
	logic [TABLE_W-1:0]    wave_rdata;
	logic                  exp_we;
	logic                  exp_re;
	logic [TABLE_W-1:0]    exp_rdata;
	logic [7:0]            wave_idx;
	logic [SAMPLE_W-1:0]   sample;

	assign in_amp   = signed'(s_tdata[15:0]);
	assign in_cv    = s_tdata[30:16];
	assign in_index = s_tdata[42:31];
	assign in_value = s_tdata[58:43];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	// result register is empty or drains this cycle
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// base rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rate_q <= BASE_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_rate_q <= cfg_data;
		end
	end

	// request fields held for the whole sample computation
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pitch_cv_q <= in_cv;
			amp_mod_q  <= in_amp;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// a finished sample loads the output register, else a taken result clears it
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= sample;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && s_tuser == REQ_SAMPLE) begin
						state_q <= ST_RD_LO;
					end
				end
				ST_RD_LO:    state_q <= ST_RD_HI;
				ST_RD_HI:    state_q <= ST_MUL_DIFF;
				ST_MUL_DIFF: state_q <= ST_SUM;
				ST_SUM:      state_q <= ST_MUL_AMP;
				ST_MUL_AMP:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath enables per step
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_RD_HI: begin
				ctl.lo_load   = 1'b1;   // lo point on the read port
				ctl.fine_load = 1'b1;   // exponent fraction on the read port
			end
			ST_MUL_DIFF: begin
				ctl.prod_load = 1'b1;
				ctl.inc_load  = 1'b1;
			end
			ST_SUM:     ctl.interp_load = 1'b1;
			ST_MUL_AMP: ctl.scale_load  = 1'b1;
			ST_DONE:    ctl.phase_step  = out_free;
			default:    ctl = '0;
		endcase
	end

	// table writes happen in the transfer cycle; wave writes past the last point drop
	assign wave_we    = in_xfer && s_tuser == REQ_WAVE_WR
	                    && {20'd0, in_index} < WAVE_POINTS;
	assign wave_waddr = in_index[WAVE_AW-1:0];
	assign exp_we     = in_xfer && s_tuser == REQ_EXP_WR;

	// lo point first, then its neighbor
	assign wave_re    = (state_q == ST_RD_LO) || (state_q == ST_RD_HI);
	assign wave_raddr = (state_q == ST_RD_HI) ? {1'b0, wave_idx} + 9'd1 : {1'b0, wave_idx};
	assign exp_re     = (state_q == ST_RD_LO);

	wtoep_ram #(
		.DEPTH (WAVE_POINTS),
		.DW    (TABLE_W)
	) u_wave_ram (
		.clk   (clk),
		.we    (wave_we),
		.waddr (wave_waddr),
		.wdata (in_value),
		.re    (wave_re),
		.raddr (wave_raddr),
		.rdata (wave_rdata)
	);

	wtoep_ram #(
		.DEPTH (EXP_ENTRIES),
		.DW    (TABLE_W)
	) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (in_index),
		.wdata (in_value),
		.re    (exp_re),
		.raddr (pitch_cv_q[EXP_AW-1:0]),
		.rdata (exp_rdata)
	);

	wtoep_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.base_rate  (base_rate_q),
		.pitch_cv   (pitch_cv_q),
		.amp_mod    (amp_mod_q),
		.wave_rdata (wave_rdata),
		.exp_rdata  (exp_rdata),
		.wave_idx   (wave_idx),
		.sample     (sample)
	);

	// a sample request always starts the table reads next cycle
	`WTOEP_ASSERT_NEXT(a_sample_starts, in_xfer && s_tuser == REQ_SAMPLE, state_q == ST_RD_LO, "sample request did not start reads")
	// a finished sample always lands in the output register
	`WTOEP_ASSERT_NEXT(a_done_presents, state_q == ST_DONE && out_free, m_tvalid && state_q == ST_IDLE, "finished sample not presented")
	// no wave write past the last point
	`WTOEP_ASSERT_NOW(a_wave_bound, wave_we, wave_waddr <= 9'd256, "wave write out of range")

endmodule

@@ design/wtoep_ram.sv @@
// ----------------------------------------------------------------------------
// wtoep_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module wtoep_ram #(
	parameter int unsigned DEPTH = 257,
	parameter int unsigned DW    = 16,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/wtoep_dpath.sv @@
// ----------------------------------------------------------------------------
// wtoep_dpath
// phase accumulator, linear interpolation, amplitude scaling, pitch increment
// ----------------------------------------------------------------------------
module wtoep_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wtoep_pkg::dp_ctl_t                  ctl,
	input  logic [wtoep_pkg::RATE_W-1:0]        base_rate,
	input  logic [wtoep_pkg::CV_W-1:0]          pitch_cv,
	input  logic signed [wtoep_pkg::SAMPLE_W-1:0] amp_mod,
	input  logic [wtoep_pkg::TABLE_W-1:0]       wave_rdata,
	input  logic [wtoep_pkg::TABLE_W-1:0]       exp_rdata,
	output logic [7:0]                          wave_idx,
	output logic [wtoep_pkg::SAMPLE_W-1:0]      sample
);
	import wtoep_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic signed [15:0] lo_q;
	logic [38:0]        fine_s1;
	logic signed [33:0] diff_prod_s2;
	logic [PHASE_W-1:0] inc_q;
	logic signed [31:0] interp_s3;
	logic signed [47:0] scaled_s4;

	logic [30:0]        rate;
	logic [22:0]        coarse;
	logic [23:0]        fine_sum;
	logic signed [16:0] diff;
	logic signed [16:0] frac_s;
	logic signed [33:0] interp_full;
	logic signed [15:0] halved;

	// octave shift then drop 8 bits
	assign rate     = {7'd0, base_rate} << pitch_cv[14:12];
	assign coarse   = rate[30:8];
	assign fine_sum = {1'b0, fine_s1[38:16]} + {1'b0, coarse};

	// interpolation between lo (held) and hi (on the read port)
	assign diff        = {wave_rdata[15], wave_rdata} - {lo_q[15], lo_q};
	assign frac_s      = signed'({1'b0, phase_q[23:8]});
	assign interp_full = signed'({{2{lo_q[15]}}, lo_q, 16'd0}) + diff_prod_s2;

	// arithmetic halving rounds toward minus infinity
	assign halved = amp_mod >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctl.phase_step) begin
			phase_q <= phase_q + inc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lo_load) begin
			lo_q <= signed'(wave_rdata);
		end
		if (ctl.fine_load) begin
			fine_s1 <= coarse * exp_rdata;
		end
		if (ctl.prod_load) begin
			diff_prod_s2 <= diff * frac_s;
		end
		if (ctl.inc_load) begin
			inc_q <= {fine_sum, 8'd0};
		end
		if (ctl.interp_load) begin
			interp_s3 <= interp_full[31:0];
		end
		if (ctl.scale_load) begin
			scaled_s4 <= interp_s3 * halved;
		end
	end

	assign wave_idx = phase_q[31:24];
	assign sample   = scaled_s4[47:32];

endmodule
